// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tilt and yaw integrator modules.
// Each macro expands to one labeled concurrent assertion on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold while out of reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that must hold while out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/tayi_pkg.sv =====
// Package for the tilt angles and yaw integrator: widths, constants, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps

package tayi_pkg;

    localparam int CORDIC_STEPS        = 16;
    localparam int ANGLE_FRACTION_BITS = 7;
    localparam int DATA_SHIFT          = 30;
    localparam int ANGLE_UNIT_BITS     = 22;
    localparam int ROUND_SHIFT         = ANGLE_UNIT_BITS - ANGLE_FRACTION_BITS;
    localparam int YAW_SHIFT           = 24 - ANGLE_FRACTION_BITS;
    localparam int STEP_W              = $clog2(CORDIC_STEPS + 1);

    // CORDIC datapath width: 16-bit inputs at 2^30 grow by the gain and a sqrt(2).
    localparam int DW = 50;
    // Angle accumulator width (2^-22 degree, range just under +-512 degrees).
    localparam int ZW = 32;
    localparam int ACC_W = 48;

    localparam logic signed [ZW-1:0] HALF_TURN = 32'sd754974720;
    localparam logic signed [31:0]   GAIN_Q30  = 32'sd1768195363;
    localparam logic [15:0]          YAW_GAIN_RESET = 16'd12807;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_z;
    } t_sample;

    function automatic logic signed [ZW-1:0] atan_units(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 32'sd188743680;
                5'd1:  v = 32'sd111421900;
                5'd2:  v = 32'sd58872272;
                5'd3:  v = 32'sd29884485;
                5'd4:  v = 32'sd15000234;
                5'd5:  v = 32'sd7507429;
                5'd6:  v = 32'sd3754631;
                5'd7:  v = 32'sd1877430;
                5'd8:  v = 32'sd938729;
                5'd9:  v = 32'sd469366;
                5'd10: v = 32'sd234683;
                5'd11: v = 32'sd117342;
                5'd12: v = 32'sd58671;
                5'd13: v = 32'sd29335;
                5'd14: v = 32'sd14668;
                5'd15: v = 32'sd7334;
                5'd16: v = 32'sd3667;
                5'd17: v = 32'sd1833;
                5'd18: v = 32'sd917;
                5'd19: v = 32'sd458;
                5'd20: v = 32'sd229;
                5'd21: v = 32'sd115;
                5'd22: v = 32'sd57;
                5'd23: v = 32'sd29;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hdl/tayi_queue.sv =====
// Two-entry item queue between the front and the back of the integrator.
// Depends on tayi_pkg for the sample type and queue depth.
`timescale 1ns / 1ps

module tayi_queue import tayi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sample i_data,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_sample o_data
);

    t_sample             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMP(a_no_overflow, i_push, !o_full)
    `ASSERT_IMP(a_no_underflow, i_pop, !o_empty)

endmodule

// ===== hdl/tayi_back.sv =====
// Back part: shared CORDIC for roll then pitch, yaw accumulation, output register.
// Depends on tayi_pkg.
`timescale 1ns / 1ps

module tayi_back import tayi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_yaw_gain_we,
    input  logic [15:0]              i_yaw_gain,
    input  logic                     i_q_empty,
    input  t_sample                  i_q_data,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [15:0]       o_roll_angle,
    output logic signed [14:0]       o_pitch_angle,
    output logic signed [30:0]       o_yaw_angle
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROLL  = 5'b00010,
        S_PMUL  = 5'b00100,
        S_PITCH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic signed [DW-1:0]     r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0]     r_z, n_z, r_roll_z;
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [15:0]       r_ax;
    logic [15:0]              r_gain;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_ovalid;
    logic signed [15:0]       r_roll;
    logic signed [14:0]       r_pitch;
    logic signed [30:0]       r_yaw;

    // Shared CORDIC step.
    logic signed [DW-1:0] w_dx, w_dy;
    logic [4:0]           w_idx;
    assign w_idx = 5'(r_step);
    assign w_dx  = r_y >>> r_step;
    assign w_dy  = r_x >>> r_step;

    // Pre-rotation for a fresh vector.
    function automatic logic [DW+DW+ZW-1:0] prerot(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] y);
        logic signed [ZW-1:0] z0;
        begin
            z0 = '0;
            if (x < 0) begin
                z0 = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x  = -x;
                y  = -y;
            end
            return {x, y, z0};
        end
    endfunction

    logic signed [DW-1:0] w_px, w_py, w_mx, w_my;
    logic signed [ZW-1:0] w_pz, w_mz;
    logic signed [DW-1:0] w_roll_x, w_roll_y, w_pit_y;
    logic signed [63:0]   w_prod;
    assign w_roll_x = DW'(i_q_data.accel_z) <<< DATA_SHIFT;
    assign w_roll_y = DW'(i_q_data.accel_y) <<< DATA_SHIFT;
    assign {w_px, w_py, w_pz} = prerot(w_roll_x, w_roll_y);
    assign w_prod  = 64'(-17'(r_ax)) * 64'(GAIN_Q30);
    assign w_pit_y = DW'(w_prod);
    assign {w_mx, w_my, w_mz} = prerot(r_x, w_pit_y);

    logic w_zero;
    logic w_last;
    assign w_last = (r_step == STEP_W'(CORDIC_STEPS - 1));

    // Yaw accumulate with saturation. The increment fits 33 signed bits, and the
    // sum then fits 49, so the top three bits tell whether the 48-bit range is left.
    logic signed [32:0]      w_inc;
    logic signed [ACC_W+1:0] w_sum;
    logic signed [ACC_W-1:0] w_acc_sat;
    assign w_inc = 33'(i_q_data.gyro_z) * 33'($signed({1'b0, r_gain}));
    assign w_sum = (ACC_W+2)'(r_acc) + (ACC_W+2)'(w_inc);
    always_comb begin
        if (!w_sum[ACC_W+1] && (|w_sum[ACC_W:ACC_W-1]))
            w_acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
        else if (w_sum[ACC_W+1] && !(&w_sum[ACC_W:ACC_W-1]))
            w_acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        else
            w_acc_sat = w_sum[ACC_W-1:0];
    end

    function automatic logic signed [ZW-1:0] rnd(input logic signed [ZW-1:0] z);
        begin
            return (z + ZW'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        end
    endfunction

    logic signed [ZW-1:0] w_roll_r, w_pit_r;
    assign w_roll_r = rnd(r_roll_z);
    assign w_pit_r  = rnd(r_z);
    assign w_zero   = (i_q_data.accel_y == 0) && (i_q_data.accel_z == 0);

    always_comb begin
        n_state = r_state;
        n_x = r_x; n_y = r_y; n_z = r_z; n_step = r_step;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty && !r_ovalid) begin
                    n_x = w_px; n_y = w_py; n_z = w_pz; n_step = '0;
                    n_state = S_ROLL;
                end
            end
            S_ROLL, S_PITCH: begin
                if (r_y >= 0) begin
                    n_x = r_x + w_dx; n_y = r_y - w_dy; n_z = r_z + atan_units(w_idx);
                end else begin
                    n_x = r_x - w_dx; n_y = r_y + w_dy; n_z = r_z - atan_units(w_idx);
                end
                n_step = r_step + 1'b1;
                if (w_last) n_state = (r_state == S_ROLL) ? S_PMUL : S_DONE;
            end
            S_PMUL: begin
                n_x = w_mx; n_y = w_my; n_z = w_mz; n_step = '0;
                n_state = S_PITCH;
            end
            S_DONE: begin
                o_q_pop = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Zero vectors: a zero vector keeps x and y at zero through every rotation,
    // so only the angle has to be forced to zero.
    logic r_rzero, r_pzero;

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_step <= n_step;
        if (r_state == S_IDLE) begin
            r_ax    <= i_q_data.accel_x;
            r_rzero <= w_zero;
        end
        if (r_state == S_ROLL && w_last) r_roll_z <= r_rzero ? '0 : n_z;
        if (r_state == S_PMUL) r_pzero <= r_rzero && (r_ax == 0);
        if (r_state == S_DONE) begin
            r_roll  <= 16'(w_roll_r);
            r_pitch <= r_pzero ? '0 : 15'(w_pit_r);
            r_yaw   <= 31'(w_acc_sat >>> YAW_SHIFT);
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_gain   <= YAW_GAIN_RESET;
        end else begin
            r_state <= n_state;
            if (i_yaw_gain_we) r_gain <= i_yaw_gain;
            if (r_state == S_DONE) begin
                r_acc    <= w_acc_sat;
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
    assign o_yaw_angle   = r_yaw;

`include "assert_macros.svh"
    `ASSERT_IMP(a_pop_nonempty, o_q_pop, !i_q_empty)
    `ASSERT_NEXT(a_done_valid, r_state == S_DONE, r_ovalid)
    `ASSERT_IMP(a_roll_range, r_ovalid, r_roll <= 16'sd23040 && r_roll >= -16'sd23040)

endmodule

// ===== hdl/tayi_front.sv =====
// Front part: accepts input items into the queue.
// Depends on tayi_pkg and tayi_queue.
`timescale 1ns / 1ps

module tayi_front import tayi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_sample i_data,
    input  logic    i_pop,
    output logic    o_empty,
    output t_sample o_data
);

    logic w_full, w_push;
    assign o_stall = w_full;
    assign w_push  = i_valid && !w_full;

    tayi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (i_data),
        .o_full (w_full),
        .o_empty(o_empty),
        .i_pop  (i_pop),
        .o_data (o_data)
    );

endmodule

// ===== hdl/tilt_angles_and_yaw_integrator.sv =====
// Top level of the tilt angles and yaw integrator.
// Depends on tayi_pkg, tayi_front, tayi_queue and tayi_back.
//
//  channel   | handshake            | payload
//  input     | i_valid / o_stall    | i_accel_x, i_accel_y, i_accel_z, i_gyro_z
//  result    | o_valid / i_stall    | o_roll_angle, o_pitch_angle, o_yaw_angle
//  config    | i_yaw_gain_we        | i_yaw_gain
//
// Each item passes the back end in order: one load, sixteen CORDIC rotations
// for roll, one pitch setup multiply, sixteen rotations for pitch and one finish.
// The next item loads only after the result has left, so the back end works on one item at a time.
// Reset is synchronous and active low; it clears the queue and the yaw sum and
// returns the gain to its reset value.
// The front queue holds two items, so input is taken while the back end works.
// A stalled result holds its register; the back end then waits before the next item.
`timescale 1ns / 1ps

module tilt_angles_and_yaw_integrator import tayi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_yaw_gain_we,
    input  logic [15:0]        i_yaw_gain,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [30:0] o_yaw_angle
);

    t_sample w_in, w_q;
    logic    w_empty, w_pop;

    assign w_in = '{accel_x: i_accel_x, accel_y: i_accel_y,
                    accel_z: i_accel_z, gyro_z: i_gyro_z};

    // The front only buffers items; all arithmetic lives in the back end.
    tayi_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (w_in),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_data (w_q)
    );

    tayi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_yaw_gain_we(i_yaw_gain_we),
        .i_yaw_gain   (i_yaw_gain),
        .i_q_empty    (w_empty),
        .i_q_data     (w_q),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_roll_angle (o_roll_angle),
        .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle  (o_yaw_angle)
    );

endmodule
